@@ rtl/ccs_pkg.sv @@
// shared types and constants for the contour cell crossing step
// no dependencies; used by every module in rtl
package ccs_pkg;

  localparam int PointFrac = 16;
  localparam int QuoBits   = PointFrac + 1;
  localparam int MagBits   = 33;
  localparam int RemBits   = MagBits + 1;
  localparam int CoordBits = 28;

  localparam logic [12:0] MaxGridDim = 13'd4096;

  localparam logic [1:0] CfgGridRows = 2'd0;
  localparam logic [1:0] CfgGridCols = 2'd1;

  typedef enum logic [1:0] {
    EdgeTop    = 2'd0,
    EdgeRight  = 2'd1,
    EdgeBottom = 2'd2,
    EdgeLeft   = 2'd3
  } edge_e;

  // per-cell decision carried alongside the divider
  typedef struct packed {
    logic [1:0]  exit_edge;
    logic        point_valid;
    logic        cell_done;
    logic [2:0]  crossing_count;
    logic        bad_count;
    logic [11:0] row;
    logic [11:0] col;
  } ccs_item_t;

endpackage

@@ rtl/ccs_classify.sv @@
// edge crossing test, exit edge choice and interpolation operands
// five register stages; depends on ccs_pkg
module ccs_classify (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [31:0]                z0_i,
  input  logic signed [31:0]                z1_i,
  input  logic signed [31:0]                z2_i,
  input  logic signed [31:0]                z3_i,
  input  logic [3:0]                        mask_i,
  input  logic signed [31:0]                level_i,
  input  logic [1:0]                        entry_i,
  input  logic [11:0]                       row_i,
  input  logic [11:0]                       col_i,
  output logic                              valid_o,
  output ccs_pkg::ccs_item_t                item_o,
  output logic [ccs_pkg::MagBits-1:0]       num_o,
  output logic [ccs_pkg::MagBits-1:0]       den_o
);

  // stage 1: input register
  logic               v1_q;
  logic signed [31:0] z1s_q [4];
  logic [3:0]         mask1_q;
  logic signed [31:0] lv1_q;
  logic [1:0]         ent1_q;
  logic [11:0]        row1_q, col1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z1s_q[0] <= z0_i;
      z1s_q[1] <= z1_i;
      z1s_q[2] <= z2_i;
      z1s_q[3] <= z3_i;
      mask1_q  <= mask_i;
      lv1_q    <= level_i;
      ent1_q   <= entry_i;
      row1_q   <= row_i;
      col1_q   <= col_i;
    end
  end

  // stage 2: crossings, count, corner sum
  logic [3:0]         hit_d;
  logic [2:0]         cnt_d;
  logic signed [33:0] sum_d;
  logic               enthi_d;

  always_comb begin
    cnt_d = 3'd0;
    for (int i = 0; i < 4; i++) begin
      hit_d[i] = !mask1_q[i] && !mask1_q[(i + 1) % 4] &&
                 ((z1s_q[i] <= lv1_q) != (z1s_q[(i + 1) % 4] <= lv1_q));
      cnt_d = cnt_d + {2'b00, hit_d[i]};
    end
    sum_d = 34'(z1s_q[0]) + 34'(z1s_q[1]) + 34'(z1s_q[2]) + 34'(z1s_q[3]);
    enthi_d = z1s_q[ent1_q] > lv1_q;
  end

  logic               v2_q;
  logic [3:0]         hit2_q;
  logic [2:0]         cnt2_q;
  logic signed [33:0] sum2_q;
  logic               enthi2_q;
  logic signed [31:0] z2s_q [4];
  logic signed [31:0] lv2_q;
  logic [1:0]         ent2_q;
  logic [11:0]        row2_q, col2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit2_q   <= hit_d;
      cnt2_q   <= cnt_d;
      sum2_q   <= sum_d;
      enthi2_q <= enthi_d;
      z2s_q    <= z1s_q;
      lv2_q    <= lv1_q;
      ent2_q   <= ent1_q;
      row2_q   <= row1_q;
      col2_q   <= col1_q;
    end
  end

  // stage 3: exit edge decision, pick the exit edge's corners
  ccs_pkg::ccs_item_t item3_d;
  logic signed [31:0] zp1_d, zp2_d;
  logic [3:0]         rest;
  logic               mid_hi;
  logic [1:0]         p2;

  always_comb begin
    rest = hit2_q & ~(4'b0001 << ent2_q);
    mid_hi = sum2_q > (34'(lv2_q) <<< 2);
    item3_d.exit_edge      = ent2_q;
    item3_d.point_valid    = 1'b0;
    item3_d.cell_done      = 1'b1;
    item3_d.crossing_count = cnt2_q;
    item3_d.bad_count      = 1'b0;
    item3_d.row            = row2_q;
    item3_d.col            = col2_q;
    if (cnt2_q == 3'd2) begin
      item3_d.point_valid = 1'b1;
      if (rest[0])      item3_d.exit_edge = ccs_pkg::EdgeTop;
      else if (rest[1]) item3_d.exit_edge = ccs_pkg::EdgeRight;
      else if (rest[2]) item3_d.exit_edge = ccs_pkg::EdgeBottom;
      else              item3_d.exit_edge = ccs_pkg::EdgeLeft;
    end else if (cnt2_q == 3'd4) begin
      item3_d.point_valid = 1'b1;
      if (mid_hi != enthi2_q) item3_d.exit_edge = ent2_q - 2'd1;
      else                    item3_d.exit_edge = ent2_q + 2'd1;
      item3_d.cell_done = (ent2_q == ccs_pkg::EdgeTop) ||
                          (item3_d.exit_edge == ccs_pkg::EdgeTop);
    end else begin
      item3_d.bad_count = 1'b1;
    end
    p2    = item3_d.exit_edge + 2'd1;
    zp1_d = z2s_q[item3_d.exit_edge];
    zp2_d = z2s_q[p2];
  end

  logic               v3_q;
  ccs_pkg::ccs_item_t item3_q;
  logic signed [31:0] zp1_q, zp2_q, lv3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item3_q <= item3_d;
      zp1_q   <= zp1_d;
      zp2_q   <= zp2_d;
      lv3_q   <= lv2_q;
    end
  end

  // stage 4: signed numerator and denominator
  logic               v4_q;
  ccs_pkg::ccs_item_t item4_q;
  logic signed [33:0] num4_q, den4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item4_q <= item3_q;
      num4_q  <= 34'(lv3_q) - 34'(zp1_q);
      den4_q  <= 34'(zp2_q) - 34'(zp1_q);
    end
  end

  // stage 5: fold the sign so the divider sees magnitudes
  logic signed [33:0] numa_d, dena_d;

  always_comb begin
    numa_d = num4_q;
    dena_d = den4_q;
    if (den4_q < 0) begin
      numa_d = -num4_q;
      dena_d = -den4_q;
    end
  end

  logic v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_o <= item4_q;
      num_o  <= numa_d[ccs_pkg::MagBits-1:0];
      den_o  <= dena_d[ccs_pkg::MagBits-1:0];
    end
  end

  assign valid_o = v5_q;

endmodule

@@ rtl/ccs_divider.sv @@
// pipelined restoring divider for the edge ratio, one quotient bit a stage
// numerator never exceeds denominator when the cell has a point; depends on ccs_pkg
module ccs_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  ccs_pkg::ccs_item_t                item_i,
  input  logic [ccs_pkg::MagBits-1:0]       num_i,
  input  logic [ccs_pkg::MagBits-1:0]       den_i,
  output logic                              valid_o,
  output ccs_pkg::ccs_item_t                item_o,
  output logic [ccs_pkg::QuoBits-1:0]       quo_o
);

  localparam int N = ccs_pkg::QuoBits;

  logic                              v_q    [N];
  ccs_pkg::ccs_item_t                item_q [N];
  logic [ccs_pkg::RemBits-1:0]       rem_q  [N];
  logic [ccs_pkg::RemBits-1:0]       den_q  [N];
  logic [N-1:0]                      quo_q  [N];

  logic [ccs_pkg::RemBits-1:0]       rem_d  [N];
  logic [N-1:0]                      quo_d  [N];

  // one compare and subtract per stage
  always_comb begin
    logic [ccs_pkg::RemBits-1:0] sh;
    logic [ccs_pkg::RemBits-1:0] dv;
    logic [N-1:0]                qin;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        sh  = {1'b0, num_i};
        dv  = {1'b0, den_i};
        qin = '0;
      end else begin
        sh  = {rem_q[k-1][ccs_pkg::RemBits-2:0], 1'b0};
        dv  = den_q[k-1];
        qin = quo_q[k-1];
      end
      if (sh >= dv) begin
        rem_d[k] = sh - dv;
        quo_d[k] = {qin[N-2:0], 1'b1};
      end else begin
        rem_d[k] = sh;
        quo_d[k] = {qin[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < N; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q[0] <= item_i;
      den_q[0]  <= {1'b0, den_i};
      for (int k = 1; k < N; k++) begin
        item_q[k] <= item_q[k-1];
        den_q[k]  <= den_q[k-1];
      end
      for (int k = 0; k < N; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign item_o  = item_q[N-1];
  assign quo_o   = quo_q[N-1];

endmodule

@@ rtl/ccs_point.sv @@
// exit point placement, neighbour cell and grid bounds; output register
// depends on ccs_pkg
module ccs_point (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  ccs_pkg::ccs_item_t                item_i,
  input  logic [ccs_pkg::QuoBits-1:0]       quo_i,
  input  logic [12:0]                       grid_rows_i,
  input  logic [12:0]                       grid_cols_i,
  output logic                              valid_o,
  output logic [1:0]                        exit_edge_o,
  output logic                              point_valid_o,
  output logic [27:0]                       point_y_o,
  output logic [27:0]                       point_x_o,
  output logic signed [13:0]                next_row_o,
  output logic signed [13:0]                next_col_o,
  output logic                              left_grid_o,
  output logic                              cell_done_o,
  output logic [2:0]                        crossing_count_o,
  output logic                              bad_count_o
);

  localparam int W = ccs_pkg::CoordBits + 1;

  logic [W-1:0]       r0, r1, c0, c1, q, py, px;
  logic signed [13:0] nr, nc;
  logic signed [14:0] rlim, clim;
  logic               off;

  always_comb begin
    r0 = W'(item_i.row) << ccs_pkg::PointFrac;
    c0 = W'(item_i.col) << ccs_pkg::PointFrac;
    r1 = (W'(item_i.row) + W'(1)) << ccs_pkg::PointFrac;
    c1 = (W'(item_i.col) + W'(1)) << ccs_pkg::PointFrac;
    q  = W'(quo_i);
    nr = $signed({2'b00, item_i.row});
    nc = $signed({2'b00, item_i.col});
    case (item_i.exit_edge)
      ccs_pkg::EdgeTop: begin
        py = r0;      px = c0 + q; nr = nr - 14'sd1;
      end
      ccs_pkg::EdgeRight: begin
        py = r0 + q;  px = c1;     nc = nc + 14'sd1;
      end
      ccs_pkg::EdgeBottom: begin
        py = r1;      px = c1 - q; nr = nr + 14'sd1;
      end
      default: begin
        py = r1 - q;  px = c0;     nc = nc - 14'sd1;
      end
    endcase
    // saturate at the top of the coordinate range
    if (py[W-1]) py = {1'b0, {(W-1){1'b1}}};
    if (px[W-1]) px = {1'b0, {(W-1){1'b1}}};
    if (!item_i.point_valid) begin
      py = '0;
      px = '0;
    end
    rlim = $signed({2'b00, grid_rows_i}) - 15'sd2;
    clim = $signed({2'b00, grid_cols_i}) - 15'sd2;
    off  = !(nr >= 0 && 15'(nr) <= rlim && nc >= 0 && 15'(nc) <= clim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exit_edge_o      <= item_i.exit_edge;
      point_valid_o    <= item_i.point_valid;
      point_y_o        <= py[W-2:0];
      point_x_o        <= px[W-2:0];
      next_row_o       <= nr;
      next_col_o       <= nc;
      left_grid_o      <= off;
      cell_done_o      <= item_i.cell_done;
      crossing_count_o <= item_i.crossing_count;
      bad_count_o      <= item_i.bad_count;
    end
  end

endmodule

@@ rtl/contour_cell_crossing_step_top.sv @@
// Contour cell crossing step: one marching-squares cell per clock while the
// output is not stalled. It passes five classification stages, a
// seventeen-stage one-bit-per-stage ratio divider and the output register.
// The whole pipe advances together and holds while a result waits under
// stall. Grid size registers are to be written only while no cell is in
// flight; the block does not check. Values above 4096 are taken as 4096.
// depends on ccs_pkg, ccs_classify, ccs_divider, ccs_point
module contour_cell_crossing_step_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] corner_top_left_i,
  input  logic signed [31:0] corner_top_right_i,
  input  logic signed [31:0] corner_bottom_right_i,
  input  logic signed [31:0] corner_bottom_left_i,
  input  logic [3:0]         null_mask_i,
  input  logic signed [31:0] contour_level_i,
  input  logic [1:0]         entry_edge_i,
  input  logic [11:0]        cell_row_i,
  input  logic [11:0]        cell_col_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         exit_edge_o,
  output logic               point_valid_o,
  output logic [27:0]        point_y_o,
  output logic [27:0]        point_x_o,
  output logic signed [13:0] next_row_o,
  output logic signed [13:0] next_col_o,
  output logic               left_grid_o,
  output logic               cell_done_o,
  output logic [2:0]         crossing_count_o,
  output logic               bad_count_o
);

  // grid size registers
  logic [12:0] rows_q, cols_q, clamp;

  assign cfg_ready_o = 1'b1;
  assign clamp = (cfg_data_i > ccs_pkg::MaxGridDim) ? ccs_pkg::MaxGridDim : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ccs_pkg::MaxGridDim;
      cols_q <= ccs_pkg::MaxGridDim;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ccs_pkg::CfgGridRows) rows_q <= clamp;
      if (cfg_index_i == ccs_pkg::CfgGridCols) cols_q <= clamp;
    end
  end

  // pipe moves unless a held result blocks the output
  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic                              cls_valid;
  ccs_pkg::ccs_item_t                cls_item;
  logic [ccs_pkg::MagBits-1:0]       cls_num, cls_den;
  logic                              div_valid;
  ccs_pkg::ccs_item_t                div_item;
  logic [ccs_pkg::QuoBits-1:0]       div_quo;

  ccs_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .z0_i    (corner_top_left_i),
    .z1_i    (corner_top_right_i),
    .z2_i    (corner_bottom_right_i),
    .z3_i    (corner_bottom_left_i),
    .mask_i  (null_mask_i),
    .level_i (contour_level_i),
    .entry_i (entry_edge_i),
    .row_i   (cell_row_i),
    .col_i   (cell_col_i),
    .valid_o (cls_valid),
    .item_o  (cls_item),
    .num_o   (cls_num),
    .den_o   (cls_den)
  );

  ccs_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cls_valid),
    .item_i  (cls_item),
    .num_i   (cls_num),
    .den_i   (cls_den),
    .valid_o (div_valid),
    .item_o  (div_item),
    .quo_o   (div_quo)
  );

  ccs_point u_point (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (div_valid),
    .item_i           (div_item),
    .quo_i            (div_quo),
    .grid_rows_i      (rows_q),
    .grid_cols_i      (cols_q),
    .valid_o          (out_valid_o),
    .exit_edge_o      (exit_edge_o),
    .point_valid_o    (point_valid_o),
    .point_y_o        (point_y_o),
    .point_x_o        (point_x_o),
    .next_row_o       (next_row_o),
    .next_col_o       (next_col_o),
    .left_grid_o      (left_grid_o),
    .cell_done_o      (cell_done_o),
    .crossing_count_o (crossing_count_o),
    .bad_count_o      (bad_count_o)
  );

  // consistency of the decision fields
  a_bad_no_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_count_o |-> !point_valid_o && point_y_o == '0 && point_x_o == '0)
    else $error("bad count with a point");

  a_point_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && point_valid_o |-> crossing_count_o == 3'd2 || crossing_count_o == 3'd4)
    else $error("point with wrong crossing count");

  a_two_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crossing_count_o == 3'd2 |-> cell_done_o && !bad_count_o)
    else $error("two crossings not done");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(point_x_o) && $stable(next_row_o))
    else $error("held result changed");

endmodule

@@ tb/sv/testbench.sv @@
// testbench for contour_cell_crossing_step_top: directed and random cells
// checked against an in-bench predictor of the marching-squares step
// depends on ccs_pkg and the rtl of contour_cell_crossing_step_top
`timescale 1ns / 100ps

module testbench;

  // one expected or observed result
  typedef struct packed {
    logic [1:0]         exit_edge;
    logic               point_valid;
    logic [27:0]        point_y;
    logic [27:0]        point_x;
    logic signed [13:0] next_row;
    logic signed [13:0] next_col;
    logic               left_grid;
    logic               cell_done;
    logic [2:0]         crossing_count;
    logic               bad_count;
  } cell_result_t;

  typedef struct {
    logic signed [31:0] corner [4];
    logic [3:0]         mask;
    logic signed [31:0] level;
    logic [1:0]         entry;
    logic [11:0]        row;
    logic [11:0]        col;
  } cell_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] c_tl, c_tr, c_br, c_bl, level;
  logic [3:0] mask;
  logic [1:0] entry;
  logic [11:0] row, col;
  cell_result_t got;

  cell_result_t expected_q [$];
  int unsigned  mismatches;
  int unsigned  hold_cycles;
  int unsigned  rows_now, cols_now;

  contour_cell_crossing_step_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .corner_top_left_i(c_tl), .corner_top_right_i(c_tr),
    .corner_bottom_right_i(c_br), .corner_bottom_left_i(c_bl),
    .null_mask_i(mask), .contour_level_i(level), .entry_edge_i(entry),
    .cell_row_i(row), .cell_col_i(col),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .exit_edge_o(got.exit_edge), .point_valid_o(got.point_valid),
    .point_y_o(got.point_y), .point_x_o(got.point_x),
    .next_row_o(got.next_row), .next_col_o(got.next_col),
    .left_grid_o(got.left_grid), .cell_done_o(got.cell_done),
    .crossing_count_o(got.crossing_count), .bad_count_o(got.bad_count)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // marching-squares step prediction
  function automatic cell_result_t predict_crossing(cell_t c);
    cell_result_t res;
    longint z [4];
    bit hit [4];
    longint lv, sum, num, den, nr, nc;
    longint unsigned q, py, px, r, cc;
    int cnt, ex, p2;
    bit valid, done, bad;
    lv = c.level;
    r = c.row;
    cc = c.col;
    cnt = 0; ex = c.entry; valid = 0; done = 1; bad = 0; py = 0; px = 0;
    for (int i = 0; i < 4; i++) z[i] = c.corner[i];
    for (int i = 0; i < 4; i++) begin
      hit[i] = !c.mask[i] && !c.mask[(i + 1) % 4] &&
               ((z[i] <= lv) != (z[(i + 1) % 4] <= lv));
      if (hit[i]) cnt++;
    end
    if (cnt == 2) begin
      hit[c.entry] = 0;
      for (int i = 3; i >= 0; i--) if (hit[i]) ex = i;
      valid = 1;
    end else if (cnt == 4) begin
      sum = z[0] + z[1] + z[2] + z[3];
      done = (c.entry == ccs_pkg::EdgeTop);
      ex = ((sum > 4 * lv) != (z[c.entry] > lv)) ? (c.entry + 3) % 4 : (c.entry + 1) % 4;
      if (ex == ccs_pkg::EdgeTop) done = 1;
      valid = 1;
    end else begin
      bad = 1;
    end
    if (valid) begin
      p2 = (ex + 1) % 4;
      num = lv - z[ex];
      den = z[p2] - z[ex];
      if (den < 0) begin num = -num; den = -den; end
      q = (den > 0 && num >= 0) ? (longint'(num) << 16) / den : 0;
      case (ex)
        ccs_pkg::EdgeTop: begin
          py = r << 16;         px = (cc << 16) + q;
        end
        ccs_pkg::EdgeRight: begin
          py = (r << 16) + q;   px = (cc + 1) << 16;
        end
        ccs_pkg::EdgeBottom: begin
          py = (r + 1) << 16;   px = ((cc + 1) << 16) - q;
        end
        default: begin
          py = ((r + 1) << 16) - q; px = cc << 16;
        end
      endcase
      if (py > 64'hFFFFFFF) py = 64'hFFFFFFF;
      if (px > 64'hFFFFFFF) px = 64'hFFFFFFF;
    end
    nr = r; nc = cc;
    case (ex)
      ccs_pkg::EdgeTop:    nr--;
      ccs_pkg::EdgeRight:  nc++;
      ccs_pkg::EdgeBottom: nr++;
      default:             nc--;
    endcase
    res.exit_edge = ex;
    res.point_valid = valid;
    res.point_y = py;
    res.point_x = px;
    res.next_row = nr;
    res.next_col = nc;
    res.left_grid = !(nr >= 0 && nr <= longint'(rows_now) - 2 &&
                      nc >= 0 && nc <= longint'(cols_now) - 2);
    res.cell_done = done;
    res.crossing_count = cnt;
    res.bad_count = bad;
    return res;
  endfunction

  // send one cell and record its expected result
  task automatic send_cell(cell_t c);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    c_tl <= c.corner[0]; c_tr <= c.corner[1];
    c_br <= c.corner[2]; c_bl <= c.corner[3];
    mask <= c.mask; level <= c.level; entry <= c.entry;
    row <= c.row; col <= c.col;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_crossing(c));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_grid(logic [1:0] idx, logic [12:0] v);
    int unsigned cl;
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cl = (v > ccs_pkg::MaxGridDim) ? ccs_pkg::MaxGridDim : v;
    if (idx == ccs_pkg::CfgGridRows) rows_now = cl; else cols_now = cl;
    @(posedge clk);
  endtask

  // random cell, mostly with corners near the level so edges cross
  function automatic cell_t rand_cell();
    cell_t c;
    int unsigned k;
    k = $urandom_range(0, 9);
    c.level = $urandom;
    for (int i = 0; i < 4; i++) begin
      if (k < 7) c.corner[i] = c.level + $signed($urandom_range(0, 131072)) - 65536;
      else c.corner[i] = $urandom;
    end
    c.mask = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
    c.entry = $urandom;
    c.row = $urandom_range(0, 4094);
    c.col = $urandom_range(0, 4094);
    if ($urandom_range(0, 3) == 0) begin
      c.row = $urandom_range(0, 6);
      c.col = $urandom_range(0, 6);
    end
    return c;
  endfunction

  function automatic cell_t make_cell(int a, int b, int d, int e, int lv,
                                      logic [1:0] en, logic [11:0] r, logic [11:0] cl);
    cell_t c;
    c.corner[0] = a; c.corner[1] = b; c.corner[2] = d; c.corner[3] = e;
    c.level = lv; c.mask = 4'd0; c.entry = en; c.row = r; c.col = cl;
    return c;
  endfunction

  // result checking
  always @(posedge clk) begin
    cell_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  // receiver stall, with one long hold-off on request
  initial begin
    int unsigned g;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (out_stall) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g != 0) begin
          out_stall <= 1'b1;
          repeat (g) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic test_directed();
    cell_t c;
    send_cell(make_cell(0, 65536, 65536, 0, 32768, ccs_pkg::EdgeLeft, 0, 0));
    send_cell(make_cell(0, 65536, 65536, 0, 32768, ccs_pkg::EdgeRight, 4094, 4094));
    send_cell(make_cell(0, 0, 65536, 65536, 32768, ccs_pkg::EdgeTop, 10, 20));
    send_cell(make_cell(0, 0, 65536, 65536, 32768, ccs_pkg::EdgeBottom, 10, 20));
    send_cell(make_cell(0, 0, 0, 0, 0, ccs_pkg::EdgeTop, 3, 3));
    send_cell(make_cell(100, 0, 0, 0, 50, ccs_pkg::EdgeTop, 3, 3));
    send_cell(make_cell(0, 100, 100, 100, 50, ccs_pkg::EdgeRight, 3, 3));
    for (int e = 0; e < 4; e++) begin
      send_cell(make_cell(100, 0, 100, 0, 40, 2'(e), 5, 5));
      send_cell(make_cell(100, 0, 100, 0, 60, 2'(e), 5, 5));
      send_cell(make_cell(0, 100, 0, 100, 40, 2'(e), 0, 4094));
    end
    send_cell(make_cell(32'h80000000, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 0, ccs_pkg::EdgeLeft, 4094, 0));
    send_cell(make_cell(32'h80000000, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 32'h80000000, ccs_pkg::EdgeLeft, 4094, 0));
    send_cell(make_cell(32'h7fffffff, 32'h7fffffff, 32'h80000000,
                        32'h80000000, 32'h7ffffffe, ccs_pkg::EdgeTop, 4095, 4095));
    c = make_cell(0, 65536, 65536, 0, 32768, ccs_pkg::EdgeLeft, 1, 1);
    c.mask = 4'b0010;
    send_cell(c);
    c.mask = 4'b1111;
    send_cell(c);
  endtask

  task automatic test_random(int n);
    repeat (n) send_cell(rand_cell());
  endtask

  // receiver holds off long enough for the pipe to fill
  task automatic test_backpressure();
    hold_cycles = 80;
    test_random(120);
  endtask

  task automatic test_grid_sizes();
    logic [12:0] sizes [6] = '{13'd2, 13'd3, 13'd7, 13'd4096, 13'd8191, 13'd0};
    foreach (sizes[i]) begin
      wait_drained();
      write_grid(ccs_pkg::CfgGridRows, sizes[i]);
      write_grid(ccs_pkg::CfgGridCols, sizes[(i + 2) % 6]);
      test_random(150);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0;
    c_tl = '0; c_tr = '0; c_br = '0; c_bl = '0;
    mask = '0; level = '0; entry = '0; row = '0; col = '0;
    mismatches = 0; hold_cycles = 0;
    rows_now = 4096; cols_now = 4096;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(950);
    test_backpressure();
    test_grid_sizes();
    wait_drained();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
